// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the matrix multiply-accumulate RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/mma_pkg.sv -----
// Package for the matrix multiply-accumulate block: payload types, codes
// and fixed field widths. No dependencies.
package mma_pkg;

	localparam int MODE_W    = 3;
	localparam int IDX_IN_W  = 4;
	localparam int VALUE_W   = 40;
	localparam int SIZE_W    = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam int RSP_DEPTH = 3;
	localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
	localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_A = 3'd0,
		MODE_LOAD_B = 3'd1,
		MODE_LOAD_C = 3'd2,
		MODE_START  = 3'd3,
		MODE_READ_C = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		mode_t                      mode;
		logic [IDX_IN_W-1:0]        row;
		logic [IDX_IN_W-1:0]        col;
		logic signed [VALUE_W-1:0]  value;
	} req_item_t;

	typedef struct packed {
		logic [IDX_IN_W-1:0]        out_row;
		logic [IDX_IN_W-1:0]        out_col;
		logic signed [VALUE_W-1:0]  out_value;
		logic                       is_done;
	} rsp_item_t;

	typedef struct packed {
		logic      valid;
		rsp_item_t item;
	} rsp_push_t;

endpackage

// ----- hw/rtl/mma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/mma_out_fifo.sv -----
// Small result queue between the datapath and the response channel.
// Depends on mma_pkg for the result types and the queue depth.
`include "assert_macros.svh"

module mma_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mma_pkg::rsp_push_t             push,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output mma_pkg::rsp_item_t             rsp,
	output logic [mma_pkg::RSP_CNT_W-1:0]  count
);

	mma_pkg::rsp_item_t                    slot_q [mma_pkg::RSP_DEPTH];
	logic [mma_pkg::RSP_PTR_W-1:0]         wr_ptr_q;
	logic [mma_pkg::RSP_PTR_W-1:0]         rd_ptr_q;
	logic [mma_pkg::RSP_CNT_W-1:0]         count_q;
	logic                                  pop;

	assign rsp_valid = (count_q != '0);
	assign rsp       = slot_q[rd_ptr_q];
	assign pop       = rsp_valid && rsp_ready;
	assign count     = count_q;

	function automatic logic [mma_pkg::RSP_PTR_W-1:0] ptr_inc(
		input logic [mma_pkg::RSP_PTR_W-1:0] p
	);
		if (p == mma_pkg::RSP_PTR_W'(mma_pkg::RSP_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The top level admits a transaction only when the queue has room for it.
	`ASSERT_NEVER(a_fifo_overflow, push.valid && !pop && count_q == mma_pkg::RSP_CNT_W'(mma_pkg::RSP_DEPTH), "result queue overflow")
	`ASSERT_CLK(a_fifo_count, (push.valid && !pop) |=> (count_q == $past(count_q) + 1'b1), "result queue count did not advance")

endmodule

// ----- hw/rtl/matrix_multiply_accumulate_top.sv -----
// Load, read and completion transactions: one request per cycle while req_ready
// is high; read data is registered, then queued. A start holds req_ready low
// while n*n*n products (n = active size) issue and drain, one multiply per cycle
// on the shared multiplier and one read per cycle from each store.
// Reset clears the sequencer and the result queue and sets matrix_size to 16;
// the A, B and C stores are not cleared and hold garbage until written.
`include "assert_macros.svh"

module matrix_multiply_accumulate_top #(
	parameter int MAX_SIZE  = 16,
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS  = 40
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  mma_pkg::req_item_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output mma_pkg::rsp_item_t          rsp,
	input  logic                        cfg_we,
	input  logic [mma_pkg::SIZE_W-1:0]  cfg_wdata
);

	localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int WIDE   = 66;
	localparam logic signed [WIDE-1:0] ACC_MAX =
		$signed((WIDE'(1) << (ACC_BITS - 1)) - WIDE'(1));
	localparam logic signed [WIDE-1:0] ACC_MIN = -ACC_MAX - WIDE'(1);

	mma_pkg::state_t state_q, state_d;

	logic [mma_pkg::SIZE_W-1:0] matrix_size_q;
	logic [mma_pkg::SIZE_W-1:0] size_active;
	logic [IDX_W-1:0]           size_last;

	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             issue;
	logic             issue_end;
	logic             done_push;
	logic             pipe_empty;
	logic             room;
	logic             accept;

	logic             lda_we, ldb_we, ldc_we, start_acc, read_acc;
	logic             in_range;
	logic [IDX_W-1:0] req_r, req_c;

	logic [ELEM_BITS-1:0] a_rdata, b_rdata;
	logic [ACC_BITS-1:0]  c_rdata;
	logic                 c_we;
	logic [ADDR_W-1:0]    c_waddr, c_raddr;
	logic [ACC_BITS-1:0]  c_wdata;

	logic signed [WIDE-1:0] ld_wide;
	logic [ACC_BITS-1:0]    ld_clamped;

	// Multiply-accumulate pipeline.
	logic                     v_s1, first_s1, last_s1;
	logic [IDX_W-1:0]         i_s1, j_s1;
	logic                     v_s2, first_s2, last_s2;
	logic [IDX_W-1:0]         i_s2, j_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [ACC_BITS-1:0]      c_s2;
	logic [ACC_BITS-1:0]      acc_q;
	logic signed [WIDE-1:0]   sum_wide;
	logic [ACC_BITS-1:0]      acc_next;

	// Read pipeline.
	logic                            rd_s1, rd_inside_s1;
	logic [mma_pkg::IDX_IN_W-1:0]    rd_row_s1, rd_col_s1;
	logic signed [WIDE-1:0]          c_out_wide;

	mma_pkg::rsp_push_t              push;
	logic [mma_pkg::RSP_CNT_W-1:0]   rsp_count;

	// Active size: zero acts as one, anything above MAX_SIZE acts as MAX_SIZE.
	always_comb begin
		priority if (matrix_size_q == '0) begin
			size_active = mma_pkg::SIZE_W'(1);
		end else if (matrix_size_q > MAX_SIZE) begin
			size_active = mma_pkg::SIZE_W'(MAX_SIZE);
		end else begin
			size_active = matrix_size_q;
		end
	end
	assign size_last = IDX_W'(size_active - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= mma_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			matrix_size_q <= cfg_wdata;
		end
	end

	// Request decode.
	assign in_range = (req.row < MAX_SIZE) && (req.col < MAX_SIZE);
	assign req_r    = IDX_W'(req.row);
	assign req_c    = IDX_W'(req.col);
	assign accept   = req_valid && req_ready;

	always_comb begin
		lda_we    = 1'b0;
		ldb_we    = 1'b0;
		ldc_we    = 1'b0;
		start_acc = 1'b0;
		read_acc  = 1'b0;
		unique case (req.mode)
			mma_pkg::MODE_LOAD_A: lda_we    = accept && in_range;
			mma_pkg::MODE_LOAD_B: ldb_we    = accept && in_range;
			mma_pkg::MODE_LOAD_C: ldc_we    = accept && in_range;
			mma_pkg::MODE_START:  start_acc = accept;
			mma_pkg::MODE_READ_C: read_acc  = accept;
			default: ;
		endcase
	end

	// A C load saturates to the accumulator range.
	assign ld_wide = {{(WIDE - mma_pkg::VALUE_W){req.value[mma_pkg::VALUE_W-1]}}, req.value};
	always_comb begin
		priority if (ld_wide > ACC_MAX) begin
			ld_clamped = ACC_BITS'(ACC_MAX);
		end else if (ld_wide < ACC_MIN) begin
			ld_clamped = ACC_BITS'(ACC_MIN);
		end else begin
			ld_clamped = ACC_BITS'(ld_wide);
		end
	end

	// Sequencer.
	assign pipe_empty = !v_s1 && !v_s2;
	assign issue_end  = (i_q == size_last) && (j_q == size_last) && (k_q == size_last);
	assign room       = ({1'b0, rsp_count} + {{mma_pkg::RSP_CNT_W{1'b0}}, rd_s1})
		< (mma_pkg::RSP_CNT_W + 1)'(mma_pkg::RSP_DEPTH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mma_pkg::ST_IDLE: begin
				if (start_acc) begin
					state_d = mma_pkg::ST_RUN;
				end
			end
			mma_pkg::ST_RUN: begin
				if (issue_end) begin
					state_d = mma_pkg::ST_DRAIN;
				end
			end
			mma_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = mma_pkg::ST_IDLE;
				end
			end
			default: state_d = mma_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		issue     = 1'b0;
		done_push = 1'b0;
		unique case (state_q)
			mma_pkg::ST_IDLE:  req_ready = room;
			mma_pkg::ST_RUN:   issue     = 1'b1;
			mma_pkg::ST_DRAIN: done_push = pipe_empty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mma_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start_acc) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (issue) begin
				// k runs fastest, then j, then i.
				if (k_q == size_last) begin
					k_q <= '0;
					if (j_q == size_last) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	// Stores. A and B are read only by the sequencer; C is read at the start of
	// each element's sum and written back once its last product is added.
	mma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (lda_we),
		.waddr ({req_r, req_c}),
		.wdata (req.value[ELEM_BITS-1:0]),
		.raddr ({i_q, k_q}),
		.rdata (a_rdata)
	);

	mma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (ldb_we),
		.waddr ({req_r, req_c}),
		.wdata (req.value[ELEM_BITS-1:0]),
		.raddr ({k_q, j_q}),
		.rdata (b_rdata)
	);

	assign c_we    = ldc_we || (v_s2 && last_s2);
	assign c_waddr = (v_s2 && last_s2) ? {i_s2, j_s2} : {req_r, req_c};
	assign c_wdata = (v_s2 && last_s2) ? acc_next : ld_clamped;
	assign c_raddr = issue ? {i_q, j_q} : {req_r, req_c};

	mma_ram #(.WIDTH(ACC_BITS), .DEPTH(DEPTH)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// Stage 1 tags follow the read, stage 2 holds the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			rd_s1 <= read_acc;
		end
	end

	always_ff @(posedge clk) begin
		first_s1     <= (k_q == '0);
		last_s1      <= (k_q == size_last);
		i_s1         <= i_q;
		j_s1         <= j_q;
		first_s2     <= first_s1;
		last_s2      <= last_s1;
		i_s2         <= i_s1;
		j_s2         <= j_s1;
		prod_s2      <= $signed(a_rdata) * $signed(b_rdata);
		c_s2         <= c_rdata;
		rd_row_s1    <= req.row;
		rd_col_s1    <= req.col;
		rd_inside_s1 <= in_range;
		if (v_s2) begin
			acc_q <= acc_next;
		end
	end

	// Saturating accumulate; the first product of an element starts from C.
	always_comb begin
		logic [ACC_BITS-1:0] base;
		base     = first_s2 ? c_s2 : acc_q;
		sum_wide = {{(WIDE - ACC_BITS){base[ACC_BITS-1]}}, base}
			+ {{(WIDE - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		priority if (sum_wide > ACC_MAX) begin
			acc_next = ACC_BITS'(ACC_MAX);
		end else if (sum_wide < ACC_MIN) begin
			acc_next = ACC_BITS'(ACC_MIN);
		end else begin
			acc_next = ACC_BITS'(sum_wide);
		end
	end

	// Responses: read data or the completion marker.
	assign c_out_wide = {{(WIDE - ACC_BITS){c_rdata[ACC_BITS-1]}}, c_rdata};

	always_comb begin
		push.valid = rd_s1 || done_push;
		if (rd_s1) begin
			push.item.out_row   = rd_row_s1;
			push.item.out_col   = rd_col_s1;
			push.item.out_value = rd_inside_s1 ? mma_pkg::VALUE_W'(c_out_wide) : '0;
			push.item.is_done   = 1'b0;
		end else begin
			push.item.out_row   = '0;
			push.item.out_col   = '0;
			push.item.out_value = '0;
			push.item.is_done   = 1'b1;
		end
	end

	mma_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.count     (rsp_count)
	);

	`ASSERT_NEVER(a_single_push, rd_s1 && done_push, "read data and completion pushed together")
	`ASSERT_NEVER(a_pipe_idle, (v_s1 || v_s2) && state_q == mma_pkg::ST_IDLE, "product pipeline busy while idle")
	`ASSERT_CLK(a_done_to_idle, done_push |=> (state_q == mma_pkg::ST_IDLE), "completion without return to idle")
	`ASSERT_NEVER(a_c_write_clash, ldc_we && v_s2 && last_s2, "C load collides with accumulate write-back")

endmodule

// ----- tb/sv/matrix_multiply_accumulate_top_tb.sv -----
// Self-checking testbench for matrix_multiply_accumulate_top: loads, multiplies and reads
// under random idling and back-pressure, with a scoreboard that predicts every response.
// Depends on mma_pkg and the matrix_multiply_accumulate_top RTL.
module matrix_multiply_accumulate_top_tb;

	localparam int MAX_SIZE = 16;
	localparam int ELEM_BITS = 16;
	localparam int ACC_BITS = 40;
	localparam longint ACC_HI = (longint'(1) <<< (ACC_BITS - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam int MODE_LAST = 7;
	localparam int STALL_LIMIT = 25000;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT = 7;

	class mma_scoreboard;
		logic signed [ELEM_BITS-1:0] a_elem [MAX_SIZE][MAX_SIZE];
		logic signed [ELEM_BITS-1:0] b_elem [MAX_SIZE][MAX_SIZE];
		logic signed [ACC_BITS-1:0] c_elem [MAX_SIZE][MAX_SIZE];
		int unsigned dim = MAX_SIZE;
		mma_pkg::rsp_item_t rsp_due [$];
		int errors;
		int accepted;
		int checked;
		int multiplies;

		function void set_size(logic [mma_pkg::SIZE_W-1:0] sz);
			if (sz == 0) begin
				dim = 1;
			end else if (sz > MAX_SIZE) begin
				dim = MAX_SIZE;
			end else begin
				dim = 32'(sz);
			end
		endfunction

		// C saturates after every single product, so the order of k matters.
		function void multiply_accumulate();
			longint acc;
			longint prod;
			int i;
			int j;
			int k;
			for (i = 0; i < dim; i++) begin
				for (j = 0; j < dim; j++) begin
					acc = longint'(c_elem[i][j]);
					for (k = 0; k < dim; k++) begin
						prod = longint'(a_elem[i][k]) * longint'(b_elem[k][j]);
						if (prod > 0 && acc > ACC_HI - prod) begin
							acc = ACC_HI;
						end else if (prod < 0 && acc < ACC_LO - prod) begin
							acc = ACC_LO;
						end else begin
							acc = acc + prod;
						end
					end
					c_elem[i][j] = acc[ACC_BITS-1:0];
				end
			end
		endfunction

		function void note_request(mma_pkg::req_item_t t);
			mma_pkg::rsp_item_t want;
			accepted++;
			want = '0;
			case (t.mode)
				mma_pkg::MODE_LOAD_A: a_elem[t.row][t.col] = t.value[ELEM_BITS-1:0];
				mma_pkg::MODE_LOAD_B: b_elem[t.row][t.col] = t.value[ELEM_BITS-1:0];
				mma_pkg::MODE_LOAD_C: c_elem[t.row][t.col] = t.value;
				mma_pkg::MODE_START: begin
					multiply_accumulate();
					multiplies++;
					want.is_done = 1'b1;
					rsp_due.push_back(want);
				end
				mma_pkg::MODE_READ_C: begin
					want.out_row = t.row;
					want.out_col = t.col;
					want.out_value = c_elem[t.row][t.col];
					rsp_due.push_back(want);
				end
				default: ;
			endcase
		endfunction

		function void check_response(mma_pkg::rsp_item_t got);
			mma_pkg::rsp_item_t want;
			if (rsp_due.size() == 0) begin
				$error("response with nothing outstanding: row %0d col %0d value %0d done %0b",
					got.out_row, got.out_col, got.out_value, got.is_done);
				errors++;
				return;
			end
			want = rsp_due.pop_front();
			checked++;
			if (got.out_row !== want.out_row) begin
				$error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
				errors++;
			end
			if (got.out_col !== want.out_col) begin
				$error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
				errors++;
			end
			if (got.out_value !== want.out_value) begin
				$error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
				errors++;
			end
			if (got.is_done !== want.is_done) begin
				$error("is_done: expected %0b, actual %0b", want.is_done, got.is_done);
				errors++;
			end
		endfunction

		function void report_leftover();
			if (rsp_due.size() != 0) begin
				$error("%0d responses never arrived", rsp_due.size());
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	mma_pkg::req_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	mma_pkg::rsp_item_t rsp;
	logic cfg_we = 1'b0;
	logic [mma_pkg::SIZE_W-1:0] cfg_wdata = '0;

	mma_scoreboard sb = new();

	// Entries written since reset; the stores hold garbage until then.
	bit a_ok [MAX_SIZE][MAX_SIZE];
	bit b_ok [MAX_SIZE][MAX_SIZE];
	bit c_ok [MAX_SIZE][MAX_SIZE];
	bit calm;
	int hold_asked;
	int hold_taken;
	int hold_left;
	int quiet_cycles;

	matrix_multiply_accumulate_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			sb.note_request(req);
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.check_response(rsp);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response side: random stalls, plus one long hold-off when asked for.
	always @(negedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic logic [mma_pkg::VALUE_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[mma_pkg::VALUE_W-1:0];
	endfunction

	// Element values: the upper bits are often junk that the block must drop.
	function automatic logic [mma_pkg::VALUE_W-1:0] elem_value();
		longint s;
		case ($urandom_range(9))
			5: s = 32767;
			6: s = -32768;
			7: s = 0;
			8: s = -1;
			9: s = longint'($urandom_range(4095)) - 2048;
			default: return rand_word();
		endcase
		return s[mma_pkg::VALUE_W-1:0];
	endfunction

	function automatic logic [mma_pkg::VALUE_W-1:0] acc_value();
		longint s;
		case ($urandom_range(9))
			4: s = ACC_HI;
			5: s = ACC_LO;
			6: s = 0;
			7: s = -1;
			8, 9: s = longint'($urandom_range(1 << 24)) - (1 << 23);
			default: return rand_word();
		endcase
		return s[mma_pkg::VALUE_W-1:0];
	endfunction

	function automatic int pick_index(int n);
		if ($urandom_range(99) < 80) begin
			return $urandom_range(n - 1);
		end
		return $urandom_range(MAX_SIZE - 1);
	endfunction

	task automatic send_req(input mma_pkg::req_item_t item);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_load(mma_pkg::mode_t m, int r, int c,
		logic [mma_pkg::VALUE_W-1:0] v);
		mma_pkg::req_item_t item;
		item.mode = m;
		item.row = mma_pkg::IDX_IN_W'(r);
		item.col = mma_pkg::IDX_IN_W'(c);
		item.value = v;
		case (m)
			mma_pkg::MODE_LOAD_A: a_ok[r][c] = 1'b1;
			mma_pkg::MODE_LOAD_B: b_ok[r][c] = 1'b1;
			mma_pkg::MODE_LOAD_C: c_ok[r][c] = 1'b1;
			default: ;
		endcase
		send_req(item);
	endtask

	task automatic send_read(int r, int c);
		mma_pkg::req_item_t item;
		item.mode = mma_pkg::MODE_READ_C;
		item.row = mma_pkg::IDX_IN_W'(r);
		item.col = mma_pkg::IDX_IN_W'(c);
		item.value = rand_word();
		send_req(item);
	endtask

	task automatic send_stray(int code, int r, int c);
		mma_pkg::req_item_t item;
		item.mode = mma_pkg::mode_t'(code);
		item.row = mma_pkg::IDX_IN_W'(r);
		item.col = mma_pkg::IDX_IN_W'(c);
		item.value = rand_word();
		send_req(item);
	endtask

	task automatic issue_start(int n);
		mma_pkg::req_item_t item;
		int i;
		int j;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				if (!a_ok[i][j]) send_load(mma_pkg::MODE_LOAD_A, i, j, elem_value());
				if (!b_ok[i][j]) send_load(mma_pkg::MODE_LOAD_B, i, j, elem_value());
				if (!c_ok[i][j]) send_load(mma_pkg::MODE_LOAD_C, i, j, acc_value());
			end
		end
		item.mode = mma_pkg::MODE_START;
		item.row = mma_pkg::IDX_IN_W'($urandom_range(MAX_SIZE - 1));
		item.col = mma_pkg::IDX_IN_W'($urandom_range(MAX_SIZE - 1));
		item.value = rand_word();
		send_req(item);
	endtask

	task automatic random_item(int n, bit with_start);
		int pick;
		int r;
		int c;
		pick = $urandom_range(99);
		r = pick_index(n);
		c = pick_index(n);
		if (pick < 22) begin
			send_load(mma_pkg::MODE_LOAD_A, r, c, elem_value());
		end else if (pick < 44) begin
			send_load(mma_pkg::MODE_LOAD_B, r, c, elem_value());
		end else if (pick < 60) begin
			send_load(mma_pkg::MODE_LOAD_C, r, c, acc_value());
		end else if (pick < 66) begin
			send_stray($urandom_range(MODE_LAST, mma_pkg::MODE_READ_C + 1), r, c);
		end else if (pick >= 91 && with_start) begin
			issue_start(n);
		end else if (c_ok[r][c]) begin
			send_read(r, c);
		end else begin
			send_load(mma_pkg::MODE_LOAD_C, r, c, acc_value());
		end
	endtask

	// Drop valid and wait until every response is in and the pipeline is quiet.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.rsp_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [mma_pkg::SIZE_W-1:0] sz);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		sb.set_size(sz);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [mma_pkg::SIZE_W-1:0] sz, int count, bit with_start);
		int n;
		write_size(sz);
		n = sb.dim;
		repeat (count) random_item(n, with_start);
		issue_start(n);
		repeat (4) send_read($urandom_range(n - 1), $urandom_range(n - 1));
	endtask

	// The response side stalls for a long time while reads keep coming, so the
	// result queue fills and the block has to push back on requests.
	task automatic backlog_reads(int n, int count);
		int r;
		int c;
		hold_asked++;
		repeat (count) begin
			r = $urandom_range(n - 1);
			c = $urandom_range(n - 1);
			if (!c_ok[r][c]) begin
				r = 0;
				c = 0;
			end
			send_read(r, c);
		end
	endtask

	initial begin
		int code;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Two by two with saturation at both ends and junk in the upper value bits.
		write_size(5'd2);
		send_load(mma_pkg::MODE_LOAD_A, 0, 0, 40'h00_0000_7FFF);
		send_load(mma_pkg::MODE_LOAD_A, 0, 1, 40'hFF_FFFF_8000);
		send_load(mma_pkg::MODE_LOAD_A, 1, 0, 40'h5A_A5A5_FFFF);
		send_load(mma_pkg::MODE_LOAD_A, 1, 1, 40'h00_0000_0000);
		send_load(mma_pkg::MODE_LOAD_B, 0, 0, 40'h00_0000_7FFF);
		send_load(mma_pkg::MODE_LOAD_B, 0, 1, 40'h12_3456_8000);
		send_load(mma_pkg::MODE_LOAD_B, 1, 0, 40'hAB_CDEF_0001);
		send_load(mma_pkg::MODE_LOAD_B, 1, 1, 40'hFF_FFFF_8000);
		send_load(mma_pkg::MODE_LOAD_C, 0, 0, 40'h7F_FFFF_FFFF);
		send_load(mma_pkg::MODE_LOAD_C, 0, 1, 40'h80_0000_0000);
		send_load(mma_pkg::MODE_LOAD_C, 1, 0, 40'h00_0000_0000);
		send_load(mma_pkg::MODE_LOAD_C, 1, 1, 40'hFF_FFFF_FFFF);
		issue_start(2);
		send_read(0, 0);
		send_read(0, 1);
		send_read(1, 0);
		send_read(1, 1);
		for (code = mma_pkg::MODE_READ_C + 1; code <= MODE_LAST; code++) begin
			send_stray(code, MAX_SIZE - 1, MAX_SIZE - 1);
		end
		send_load(mma_pkg::MODE_LOAD_A, MAX_SIZE - 1, MAX_SIZE - 1, 40'hFF_FFFF_FFFF);
		send_load(mma_pkg::MODE_LOAD_B, MAX_SIZE - 1, MAX_SIZE - 1, 40'h00_0000_7FFF);
		send_load(mma_pkg::MODE_LOAD_C, MAX_SIZE - 1, MAX_SIZE - 1, 40'h80_0000_0000);
		send_read(MAX_SIZE - 1, MAX_SIZE - 1);

		run_phase(5'd1, 30, 1'b1);
		run_phase(5'd0, 20, 1'b1);
		run_phase(5'd3, 50, 1'b1);
		backlog_reads(3, 40);
		calm = 1'b1;
		run_phase(5'd5, 40, 1'b1);
		calm = 1'b0;
		run_phase(5'd4, 35, 1'b1);
		run_phase(5'd2, 30, 1'b1);
		run_phase(5'd31, 10, 1'b0);
		run_phase(5'd8, 15, 1'b0);
		run_phase(5'd16, 15, 1'b0);
		run_phase(5'd1, 20, 1'b1);
		settle();

		sb.report_leftover();
		$display("Run covered %0d requests, %0d checked responses and %0d multiply runs,",
			sb.accepted, sb.checked, sb.multiplies);
		$display("at sizes 0 through 31, with saturating sums, stray modes and a stalled output.");
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
